/* rtl/baro_temp_pressure_compensation_unit_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the barometer compensation unit.
// Each macro is empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef BARO_TEMP_PRESSURE_COMPENSATION_UNIT_DEFINES_SVH
`define BARO_TEMP_PRESSURE_COMPENSATION_UNIT_DEFINES_SVH
`ifndef SYNTH
`define BTPC_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`define BTPC_ASSERT_NOW(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");
`else
`define BTPC_ASSERT_NEXT(label, clk, rst, pre, post)
`define BTPC_ASSERT_NOW(label, clk, rst, pre, post)
`endif
`endif

/* rtl/btpc_pkg.sv */
// ----------------------------------------------------------------------------
// Barometer compensation package
// Shared types, register indexes and the controller/datapath command set.
// ----------------------------------------------------------------------------
package btpc_pkg;

  localparam int RawW = 20;
  localparam int CfgIdxW = 3;
  localparam int OpW = 5;

  localparam logic [CfgIdxW-1:0] REG_T1_T2 = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_T3    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_P1_P2 = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_P3_P4 = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_P5_P6 = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_P7_P8 = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_P9    = 3'd6;

  // Datapath micro-operations, one per cycle while the divider is not running.
  localparam logic [OpW-1:0] OP_NOP  = 5'd0;
  localparam logic [OpW-1:0] OP_T0   = 5'd1;
  localparam logic [OpW-1:0] OP_T1   = 5'd2;
  localparam logic [OpW-1:0] OP_T2   = 5'd3;
  localparam logic [OpW-1:0] OP_T3   = 5'd4;
  localparam logic [OpW-1:0] OP_T4   = 5'd5;
  localparam logic [OpW-1:0] OP_T5   = 5'd6;
  localparam logic [OpW-1:0] OP_P0   = 5'd7;
  localparam logic [OpW-1:0] OP_P1   = 5'd8;
  localparam logic [OpW-1:0] OP_P2   = 5'd9;
  localparam logic [OpW-1:0] OP_P3   = 5'd10;
  localparam logic [OpW-1:0] OP_P4   = 5'd11;
  localparam logic [OpW-1:0] OP_P5   = 5'd12;
  localparam logic [OpW-1:0] OP_P6   = 5'd13;
  localparam logic [OpW-1:0] OP_P7   = 5'd14;
  localparam logic [OpW-1:0] OP_P8   = 5'd15;
  localparam logic [OpW-1:0] OP_P9   = 5'd16;
  localparam logic [OpW-1:0] OP_DIVS = 5'd17;
  localparam logic [OpW-1:0] OP_Q0   = 5'd18;
  localparam logic [OpW-1:0] OP_Q1   = 5'd19;
  localparam logic [OpW-1:0] OP_Q2   = 5'd20;
  localparam logic [OpW-1:0] OP_Q3   = 5'd21;
  localparam logic [OpW-1:0] OP_Q4   = 5'd22;
  localparam logic [OpW-1:0] OP_Q5   = 5'd23;

  typedef struct packed {
    logic [OpW-1:0] op;
    logic           load;
    logic           div_step;
  } dp_cmd_t;

  typedef struct packed {
    logic div_zero;
    logic div_done;
  } dp_status_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] temperature_centi;
    logic [31:0] pressure_pa;
    logic        div_zero;
  } result_t;

  typedef struct packed {
    logic             mode;
    logic [RawW-1:0]  raw_sample;
  } sample_t;

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  // Arithmetic right shift of a 32-bit two's complement word.
  function automatic logic [31:0] asr(input logic [31:0] x, input int n);
    return $signed(x) >>> n;
  endfunction

endpackage

/* rtl/btpc_if.sv */
// ----------------------------------------------------------------------------
// Valid/ready channel
// Carries one payload transaction per valid and ready handshake.
// ----------------------------------------------------------------------------
interface btpc_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/baro_temp_pressure_compensation_unit.sv */
// ----------------------------------------------------------------------------
// Barometer temperature and pressure compensation unit
// Channel  | dir | payload
// sample   | in  | mode, raw_sample
// result   | out | kind, temperature_centi, pressure_pa, div_zero
// A temperature transaction runs micro-operations T0 to T5 on the shared
// multiplier before the result is offered, and a pressure transaction runs P0
// to P9, the divider set-up, the 32-step divider and then Q0 to Q5.
// A pressure transaction with a zero divisor skips the divider and Q0 to Q5.
// The next sample is taken in the cycle that the result is taken.
// Reset is synchronous and clears the calibration and fine temperature.
// ----------------------------------------------------------------------------
`include "baro_temp_pressure_compensation_unit_defines.svh"
module baro_temp_pressure_compensation_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  btpc_if.sink        sample,
  btpc_if.source      result
);
  import btpc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  result_t    res;
  sample_t    smp;

  assign smp = sample.data;

  btpc_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(sample.valid), .in_mode(smp.mode), .in_ready(sample.ready),
    .out_valid(result.valid), .out_ready(result.ready),
    .cmd(cmd), .status(status)
  );

  btpc_dp u_dp (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .sample(smp), .cmd(cmd), .status(status), .result(res)
  );

  assign result.data = res;

  `BTPC_ASSERT_NOW(a_no_load_busy, clk, rst, cmd.load, sample.ready)
  `BTPC_ASSERT_NOW(a_idle_no_op, clk, rst, result.valid, cmd.op == OP_NOP)
  `BTPC_ASSERT_NEXT(a_load_starts, clk, rst, cmd.load, !result.valid)

endmodule

/* rtl/btpc_ctrl.sv */
// ----------------------------------------------------------------------------
// Compensation controller
// Sequences the micro-operations of one sample and the output handshake.
// ----------------------------------------------------------------------------
module btpc_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_mode,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  output btpc_pkg::dp_cmd_t      cmd,
  input  btpc_pkg::dp_status_t   status
);
  import btpc_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]     state, state_next;
  logic [OpW-1:0] op, op_next;

  assign in_ready  = (state == S_IDLE) || (state == S_OUT && out_ready);
  assign out_valid = (state == S_OUT);

  always_comb begin
    cmd.load     = in_valid && in_ready;
    cmd.op       = (state == S_RUN) ? op : OP_NOP;
    cmd.div_step = (state == S_DIV);
  end

  always_comb begin
    state_next = state;
    op_next    = op;
    unique case (state)
      S_IDLE, S_OUT: begin
        if (state == S_OUT && out_ready) state_next = S_IDLE;
        if (in_valid && in_ready) begin
          state_next = S_RUN;
          op_next    = in_mode ? OP_P0 : OP_T0;
        end
      end
      S_RUN: begin
        priority if (op == OP_T5 || op == OP_Q5) begin
          state_next = S_OUT;
        end else if (op == OP_DIVS) begin
          if (status.div_zero) state_next = S_OUT;
          else begin
            state_next = S_DIV;
            op_next    = OP_Q0;
          end
        end else begin
          op_next = op + OpW'(1);
        end
      end
      S_DIV: begin
        if (status.div_done) state_next = S_RUN;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= OP_NOP;
    end else begin
      state <= state_next;
      op    <= op_next;
    end
  end

endmodule

/* rtl/btpc_dp.sv */
// ----------------------------------------------------------------------------
// Compensation datapath
// Calibration registers, one shared 32x32 multiplier and a radix-2 divider.
// ----------------------------------------------------------------------------
module btpc_dp (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [2:0]             cfg_index,
  input  logic [31:0]            cfg_data,
  input  btpc_pkg::sample_t      sample,
  input  btpc_pkg::dp_cmd_t      cmd,
  output btpc_pkg::dp_status_t   status,
  output btpc_pkg::result_t      result
);
  import btpc_pkg::*;

  logic [31:0] cal_t1_t2, cal_p1_p2, cal_p3_p4, cal_p5_p6, cal_p7_p8;
  logic [15:0] cal_t3, cal_p9;
  logic [31:0] fine_t;
  logic        mode;
  logic [19:0] raw;
  logic [31:0] ra, rb, rc, rd, acc;
  logic [31:0] ma, mb, prod;
  logic [31:0] num, quo, rem;
  logic [5:0]  cnt;
  logic [32:0] rem_try;
  logic        dz;

  logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  assign t1 = {16'd0, cal_t1_t2[15:0]};
  assign t2 = sx16(cal_t1_t2[31:16]);
  assign t3 = sx16(cal_t3);
  assign p1 = {16'd0, cal_p1_p2[15:0]};
  assign p2 = sx16(cal_p1_p2[31:16]);
  assign p3 = sx16(cal_p3_p4[15:0]);
  assign p4 = sx16(cal_p3_p4[31:16]);
  assign p5 = sx16(cal_p5_p6[15:0]);
  assign p6 = sx16(cal_p5_p6[31:16]);
  assign p7 = sx16(cal_p7_p8[15:0]);
  assign p8 = sx16(cal_p7_p8[31:16]);
  assign p9 = sx16(cal_p9);

  assign prod = ma * mb;

  always_comb begin
    ma = 32'd0;
    mb = 32'd0;
    unique case (cmd.op)
      OP_T0: begin ma = {15'd0, raw[19:3]} - (t1 << 1); mb = t2; end
      OP_T1: begin ma = rd; mb = rd; end
      OP_T2: begin ma = $signed(acc) >>> 12; mb = t3; end
      OP_T4: begin ma = fine_t; mb = 32'd5; end
      OP_P1: begin ma = $signed(ra) >>> 2; mb = $signed(ra) >>> 2; end
      OP_P2: begin ma = $signed(acc) >>> 11; mb = p6; end
      OP_P3: begin ma = ra; mb = p5; end
      OP_P4: begin ma = p3; mb = $signed(rc) >>> 13; end
      OP_P5: begin ma = p2; mb = ra; end
      OP_P7: begin ma = 32'd32768 + rb; mb = p1; end
      OP_P9: begin ma = rd; mb = 32'd3125; end
      OP_Q1: begin ma = {3'd0, quo[31:3]}; mb = {3'd0, quo[31:3]}; end
      OP_Q2: begin ma = p9; mb = {13'd0, acc[31:13]}; end
      OP_Q3: begin ma = {2'd0, quo[31:2]}; mb = p8; end
      default: begin ma = 32'd0; mb = 32'd0; end
    endcase
  end

  assign rem_try = {rem, num[31]} - {1'b0, rb};
  assign status.div_zero = (cmd.op == OP_DIVS) && (rb == 32'd0);
  assign status.div_done = cmd.div_step && (cnt == 6'd31);

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_t1_t2 <= '0; cal_t3 <= '0; cal_p1_p2 <= '0; cal_p3_p4 <= '0;
      cal_p5_p6 <= '0; cal_p7_p8 <= '0; cal_p9 <= '0; fine_t <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_T1_T2: cal_t1_t2 <= cfg_data;
          REG_T3:    cal_t3 <= cfg_data[15:0];
          REG_P1_P2: cal_p1_p2 <= cfg_data;
          REG_P3_P4: cal_p3_p4 <= cfg_data;
          REG_P5_P6: cal_p5_p6 <= cfg_data;
          REG_P7_P8: cal_p7_p8 <= cfg_data;
          REG_P9:    cal_p9 <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (cmd.op == OP_T3) fine_t <= ra + asr(acc, 14);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode <= sample.mode;
      raw  <= sample.raw_sample;
      dz   <= 1'b0;
      cnt  <= '0;
    end
    if (cmd.div_step) begin
      num <= {num[30:0], 1'b0};
      cnt <= cnt + 6'd1;
      if (!rem_try[32]) begin
        rem <= rem_try[31:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= {rem[30:0], num[31]};
        quo <= {quo[30:0], 1'b0};
      end
    end
    unique case (cmd.op)
      OP_T0: begin
        ra <= $signed(prod) >>> 11;
        rd <= {16'd0, raw[19:4]} - t1;
      end
      OP_T1: acc <= prod;
      OP_T2: acc <= prod;
      OP_T4: acc <= prod + 32'd128;
      OP_T5: rc <= $signed(acc) >>> 8;
      OP_P0: ra <= asr(fine_t, 1) - 32'd64000;
      OP_P1: begin acc <= prod; rc <= prod; end
      OP_P2: acc <= prod;
      OP_P3: acc <= acc + (prod << 1);
      OP_P4: begin
        rd <= asr(acc, 2) + (p4 << 16);
        acc <= $signed(prod) >>> 3;
      end
      OP_P5: rb <= asr(acc + asr(prod, 1), 18);
      OP_P6: rd <= (32'd1048576 - {12'd0, raw}) - asr(rd, 12);
      OP_P7: rb <= $signed(prod) >>> 15;
      OP_P9: rd <= prod;
      OP_DIVS: begin
        dz  <= (rb == 32'd0);
        rem <= '0;
        quo <= '0;
        num <= rd[31] ? rd : {rd[30:0], 1'b0};
        rc  <= 32'd0;
      end
      OP_Q0: if (rd[31]) quo <= {quo[30:0], 1'b0};
      OP_Q1: acc <= prod;
      OP_Q2: acc <= $signed(prod) >>> 12;
      OP_Q3: acc <= acc + asr(prod, 13);
      OP_Q4: acc <= quo + asr(acc + p7, 4);
      default: ;
    endcase
  end

  always_comb begin
    result.kind = mode;
    result.temperature_centi = mode ? 32'd0 : rc;
    result.pressure_pa = (!mode && 1'b1) ? 32'd0 : (dz ? 32'd0 : acc);
    result.div_zero = mode && dz;
  end

endmodule

/* dv/btpc_compensation_check.sv */
// ----------------------------------------------------------------------------
// Compensation result check
// Watches the calibration port and both channels, works out the expected
// temperature or pressure for each sample transaction, and compares every
// result transaction field by field against the oldest expectation.
// ----------------------------------------------------------------------------
module btpc_compensation_check (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic                sample_valid,
  input  logic                sample_ready,
  input  btpc_pkg::sample_t   sample_data,
  input  logic                result_valid,
  input  logic                result_ready,
  input  btpc_pkg::result_t   result_data,
  output int                  errors,
  output int                  pending,
  output int                  temp_count,
  output int                  pres_count,
  output int                  dz_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import btpc_pkg::*;

  logic [31:0] cal_t1_t2, cal_t3, cal_p1_p2, cal_p3_p4, cal_p5_p6, cal_p7_p8, cal_p9;
  logic [31:0] fine_t;
  result_t     expected_results[$];

  function automatic logic [31:0] ext16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] shr_s(input logic [31:0] x, input int n);
    return $signed(x) >>> n;
  endfunction

  function automatic result_t compensate(input sample_t s);
    result_t     r;
    logic [31:0] raw, t1, t2, t3, a, d, b;
    logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] v1, v2, q, sq, p, w1, w2;
    raw = {12'b0, s.raw_sample};
    r = '0;
    r.kind = s.mode;
    if (!s.mode) begin
      t1 = {16'b0, cal_t1_t2[15:0]};
      t2 = ext16(cal_t1_t2[31:16]);
      t3 = ext16(cal_t3[15:0]);
      a = shr_s(((raw >> 3) - (t1 << 1)) * t2, 11);
      d = (raw >> 4) - t1;
      b = shr_s(shr_s(d * d, 12) * t3, 14);
      fine_t = a + b;
      r.temperature_centi = shr_s(fine_t * 32'd5 + 32'd128, 8);
    end else begin
      p1 = {16'b0, cal_p1_p2[15:0]};
      p2 = ext16(cal_p1_p2[31:16]);
      p3 = ext16(cal_p3_p4[15:0]);
      p4 = ext16(cal_p3_p4[31:16]);
      p5 = ext16(cal_p5_p6[15:0]);
      p6 = ext16(cal_p5_p6[31:16]);
      p7 = ext16(cal_p7_p8[15:0]);
      p8 = ext16(cal_p7_p8[31:16]);
      p9 = ext16(cal_p9[15:0]);
      v1 = shr_s(fine_t, 1) - 32'd64000;
      q = shr_s(v1, 2);
      sq = q * q;
      v2 = shr_s(sq, 11) * p6;
      v2 = v2 + ((v1 * p5) << 1);
      v2 = shr_s(v2, 2) + (p4 << 16);
      v1 = shr_s(shr_s(p3 * shr_s(sq, 13), 3) + shr_s(p2 * v1, 1), 18);
      v1 = shr_s((32'd32768 + v1) * p1, 15);
      if (v1 == 0) begin
        r.div_zero = 1'b1;
      end else begin
        p = ((32'd1048576 - raw) - shr_s(v2, 12)) * 32'd3125;
        if (!p[31]) begin
          p = (p << 1) / v1;
        end else begin
          p = (p / v1) * 32'd2;
        end
        w1 = shr_s(p9 * (((p >> 3) * (p >> 3)) >> 13), 12);
        w2 = shr_s((p >> 2) * p8, 13);
        r.pressure_pa = p + shr_s(w1 + w2 + p7, 4);
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    result_t e;
    if (rst) begin
      {cal_t1_t2, cal_t3, cal_p1_p2, cal_p3_p4} = '0;
      {cal_p5_p6, cal_p7_p8, cal_p9, fine_t} = '0;
      expected_results = {};
      errors <= 0;
      temp_count <= 0;
      pres_count <= 0;
      dz_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_T1_T2: cal_t1_t2 = cfg_data;
          REG_T3:    cal_t3 = {16'b0, cfg_data[15:0]};
          REG_P1_P2: cal_p1_p2 = cfg_data;
          REG_P3_P4: cal_p3_p4 = cfg_data;
          REG_P5_P6: cal_p5_p6 = cfg_data;
          REG_P7_P8: cal_p7_p8 = cfg_data;
          REG_P9:    cal_p9 = {16'b0, cfg_data[15:0]};
          default: ;
        endcase
      end
      if (sample_valid && sample_ready) begin
        e = compensate(sample_data);
        expected_results.push_back(e);
        if (!e.kind) temp_count <= temp_count + 1;
        else pres_count <= pres_count + 1;
        if (e.div_zero) dz_count <= dz_count + 1;
      end
      if (result_valid && result_ready) begin
        if (expected_results.size() == 0) begin
          errors <= errors + 1;
          if (errors < 10) $display("Unexpected result transaction: %p", result_data);
        end else begin
          e = expected_results.pop_front();
          if (result_data !== e) begin
            errors <= errors + 1;
            if (errors < 10) begin
              $display("Mismatch: expected kind %0d temp %0d pres %0d dz %0d",
                       e.kind, $signed(e.temperature_centi), e.pressure_pa, e.div_zero);
              $display("          actual   kind %0d temp %0d pres %0d dz %0d",
                       result_data.kind, $signed(result_data.temperature_centi),
                       result_data.pressure_pa, result_data.div_zero);
            end
          end
        end
      end
    end
    pending <= expected_results.size();
  end
endmodule

/* dv/baro_temp_pressure_compensation_unit_tb.sv */
// ----------------------------------------------------------------------------
// Barometer compensation unit testbench
// Loads several calibration sets, from datasheet-like values to all-zero and
// all-ones extremes, and sends directed and random samples with random gaps
// on both channels. A separate check module predicts and compares results.
// ----------------------------------------------------------------------------
module baro_temp_pressure_compensation_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import btpc_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        idle_on = 1'b1;
  int          errors, pending, temp_count, pres_count, dz_count;

  btpc_if #(.payload_t(sample_t)) sample_ch ();
  btpc_if #(.payload_t(result_t)) result_ch ();

  always #10 clk = ~clk;

  baro_temp_pressure_compensation_unit DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .sample(sample_ch), .result(result_ch)
  );

  btpc_compensation_check u_check (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .sample_valid(sample_ch.valid), .sample_ready(sample_ch.ready),
    .sample_data(sample_ch.data),
    .result_valid(result_ch.valid), .result_ready(result_ch.ready),
    .result_data(result_ch.data),
    .errors(errors), .pending(pending), .temp_count(temp_count),
    .pres_count(pres_count), .dz_count(dz_count)
  );

  initial begin
    sample_ch.valid = 1'b0;
    sample_ch.data = '0;
    result_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    result_ch.ready <= idle_on ? ($urandom_range(0, 99) >= 20) : 1'b1;
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_calibration(input logic [31:0] t12, t3, p12, p34, p56, p78, p9);
    write_reg(REG_T1_T2, t12);
    write_reg(REG_T3, t3);
    write_reg(REG_P1_P2, p12);
    write_reg(REG_P3_P4, p34);
    write_reg(REG_P5_P6, p56);
    write_reg(REG_P7_P8, p78);
    write_reg(REG_P9, p9);
    write_reg(3'd7, $urandom);
    @(posedge clk);
  endtask

  task automatic send_sample(input logic mode, input logic [19:0] raw);
    sample_t s;
    s.mode = mode;
    s.raw_sample = raw;
    sample_ch.valid <= 1'b1;
    sample_ch.data <= s;
    do @(posedge clk); while (!sample_ch.ready);
    if (idle_on && $urandom_range(0, 99) < 20) begin
      sample_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain;
    sample_ch.valid <= 1'b0;
    repeat (2) @(posedge clk);
    wait (pending == 0);
    repeat (80) @(posedge clk);
  endtask

  task automatic random_samples(input int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: send_sample(1'($urandom_range(0, 1)), 20'($urandom_range(0, 20'hFFFFF)));
        1: send_sample(1'b0, 20'($urandom_range(20'h70000, 20'h90000)));
        default: send_sample(1'b1, 20'($urandom_range(20'h40000, 20'h70000)));
      endcase
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    load_calibration({16'd26435, 16'd27504}, 32'h0000FC18, {16'hD653, 16'd36477},
                     {16'd2855, 16'd3024}, {16'hFFF9, 16'd140}, {16'hC6F8, 16'd15500},
                     32'd6000);
    send_sample(1'b1, 20'h65A3F);
    send_sample(1'b0, 20'h7E1A0);
    send_sample(1'b1, 20'h65A3F);
    send_sample(1'b0, 20'h00000);
    send_sample(1'b1, 20'h00000);
    send_sample(1'b0, 20'hFFFFF);
    send_sample(1'b1, 20'hFFFFF);
    send_sample(1'b0, 20'h80000);
    send_sample(1'b1, 20'h7FFFF);
    random_samples(110);
    drain();

    load_calibration('0, '0, '0, '0, '0, '0, '0);
    send_sample(1'b0, 20'h12345);
    send_sample(1'b1, 20'hABCDE);
    random_samples(60);
    drain();

    load_calibration('1, '1, '1, '1, '1, '1, '1);
    send_sample(1'b1, 20'hFFFFF);
    send_sample(1'b0, 20'h00000);
    random_samples(100);
    drain();

    load_calibration(32'h8000FFFF, 32'h00008000, 32'h8000FFFF, 32'h80008000,
                     32'h80008000, 32'h80008000, 32'h00008000);
    random_samples(100);
    drain();

    load_calibration(32'h7FFF0000, 32'h00007FFF, 32'h7FFF0001, 32'h7FFF7FFF,
                     32'h7FFF7FFF, 32'h7FFF7FFF, 32'h00007FFF);
    random_samples(100);
    drain();

    idle_on <= 1'b0;
    load_calibration($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    random_samples(100);
    drain();

    idle_on <= 1'b1;
    load_calibration({16'($urandom_range(0, 65535)), 16'd27504}, $urandom,
                     {16'($urandom_range(0, 65535)), 16'($urandom_range(30000, 40000))},
                     $urandom, $urandom, $urandom, $urandom);
    random_samples(110);
    drain();

    $display("Covered %0d temperature and %0d pressure samples, %0d with a zero divisor,",
             temp_count, pres_count, dz_count);
    $display("over seven calibration sets including all-zero and all-ones extremes.");
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end
endmodule

/* filelist.f */
+incdir+rtl
rtl/btpc_pkg.sv
rtl/btpc_if.sv
rtl/btpc_ctrl.sv
rtl/btpc_dp.sv
rtl/baro_temp_pressure_compensation_unit.sv
dv/btpc_compensation_check.sv
dv/baro_temp_pressure_compensation_unit_tb.sv
